// ----- rtl/md5_pkg.sv -----
// shared constants and functions for the md5 block
package md5_pkg;
  localparam int unsigned QueueDepth = 4;
  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hefcdab89;
  localparam logic [31:0] InitC = 32'h98badcfe;
  localparam logic [31:0] InitD = 32'h10325476;
  localparam logic [7:0] PadByte = 8'h80;

  // one byte entry for the back end: byte, whether it holds a byte, and whether it ends the message
  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       last;
  } md5_entry_t;

  function automatic logic [31:0] sine_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amt(input logic [1:0] g, input logic [1:0] j);
    logic [4:0] s;
    case ({g, j})
      4'd0: s = 5'd7;  4'd1: s = 5'd12; 4'd2: s = 5'd17; 4'd3: s = 5'd22;
      4'd4: s = 5'd5;  4'd5: s = 5'd9;  4'd6: s = 5'd14; 4'd7: s = 5'd20;
      4'd8: s = 5'd4;  4'd9: s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6; 4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction
endpackage

// ----- rtl/md5_front.sv -----
// input stage: drops empty non-final items and queues the rest
module md5_front #(
  parameter int unsigned Depth = md5_pkg::QueueDepth
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [7:0]         in_data_byte,
  input  logic               in_no_byte,
  input  logic               in_final_item,
  output logic               q_valid,
  input  logic               q_take,
  output md5_pkg::md5_entry_t q_entry
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  md5_pkg::md5_entry_t mem_r [Depth];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic wr, rd;

  // classify: an item with no byte and no end mark does nothing
  assign in_full = (cnt_r == (AW+1)'(Depth));
  assign wr = in_push && !in_full && (!in_no_byte || in_final_item);
  assign rd = q_take && q_valid;
  assign q_valid = (cnt_r != '0);
  assign q_entry = mem_r[rp_r];

  // queue storage
  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wp_r] <= '{data: in_data_byte, has_byte: !in_no_byte, last: in_final_item};
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= (wp_r == AW'(Depth-1)) ? '0 : wp_r + 1'b1;
      if (rd) rp_r <= (rp_r == AW'(Depth-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end
endmodule

// ----- rtl/md5_back.sv -----
// back end: block gathering, padding and one md5 step per cycle
module md5_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_take,
  input  md5_pkg::md5_entry_t q_entry,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [63:0]        out_digest_low,
  output logic [63:0]        out_digest_high
);
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StPad  = 3'd1;
  localparam logic [2:0] StLen  = 3'd2;
  localparam logic [2:0] StComp = 3'd3;
  localparam logic [2:0] StFin  = 3'd4;

  logic [2:0]  st_r;
  logic [2:0]  ret_r;
  logic [31:0] blk_r [16];
  logic [5:0]  fill_r;
  logic [63:0] len_r, len_hold_r;
  logic [31:0] ch_r [4];
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [5:0]  rnd_r;
  logic        pad_first_r;
  logic        out_full_r;
  logic [7:0]  byte_v;
  logic        put_v;
  logic [1:0]  grp;
  logic [31:0] f_v, t_v, sum_v, rot_v;
  logic [5:0]  kmul;
  logic [4:0]  sh;

  // one compression step
  assign grp = rnd_r[5:4];
  always_comb begin
    case (grp)
      2'd0: begin f_v = (b_r & c_r) | (~b_r & d_r); kmul = rnd_r; end
      2'd1: begin f_v = (b_r & d_r) | (c_r & ~d_r); kmul = 6'(5 * rnd_r + 1); end
      2'd2: begin f_v = b_r ^ c_r ^ d_r; kmul = 6'(3 * rnd_r + 5); end
      default: begin f_v = c_r ^ (b_r | ~d_r); kmul = 6'(7 * rnd_r); end
    endcase
    sh = md5_pkg::rot_amt(grp, rnd_r[1:0]);
    sum_v = a_r + f_v + blk_r[kmul[3:0]] + md5_pkg::sine_k(rnd_r);
    rot_v = (sum_v << sh) | (sum_v >> (6'd32 - {1'b0, sh}));
    t_v = b_r + rot_v;
  end

  // byte source per state
  always_comb begin
    byte_v = 8'h00;
    put_v = 1'b0;
    q_take = 1'b0;
    case (st_r)
      StIdle: begin
        q_take = q_valid && !out_full_r;
        byte_v = q_entry.data;
        put_v = q_take && q_entry.has_byte;
      end
      StPad: begin
        put_v = 1'b1;
        byte_v = pad_first_r ? md5_pkg::PadByte : 8'h00;
      end
      StLen: begin
        put_v = 1'b1;
        byte_v = len_hold_r[8*fill_r[2:0] +: 8];
      end
      default: ;
    endcase
  end

  assign out_empty = !out_full_r;

  // sequencer
  always_ff @(posedge clk) begin
    if (put_v) begin
      if (fill_r[1:0] == 2'd0) blk_r[fill_r[5:2]] <= {24'h0, byte_v};
      else blk_r[fill_r[5:2]][8*fill_r[1:0] +: 8] <= byte_v;
    end
    if (!rst_n) begin
      st_r <= StIdle;
      ret_r <= StIdle;
      fill_r <= '0;
      len_r <= '0;
      len_hold_r <= '0;
      rnd_r <= '0;
      pad_first_r <= 1'b0;
      out_full_r <= 1'b0;
      ch_r[0] <= md5_pkg::InitA; ch_r[1] <= md5_pkg::InitB;
      ch_r[2] <= md5_pkg::InitC; ch_r[3] <= md5_pkg::InitD;
      a_r <= '0; b_r <= '0; c_r <= '0; d_r <= '0;
    end else begin
      if (out_pop && out_full_r) out_full_r <= 1'b0;
      if (put_v) fill_r <= fill_r + 1'b1;
      case (st_r)
        StIdle: if (q_take) begin
          if (q_entry.has_byte) len_r <= len_r + 64'd8;
          if (q_entry.last) begin
            len_hold_r <= len_r + (q_entry.has_byte ? 64'd8 : 64'd0);
            pad_first_r <= 1'b1;
          end
          if (put_v && fill_r == 6'd63) begin
            st_r <= StComp;
            ret_r <= q_entry.last ? StPad : StIdle;
            a_r <= ch_r[0]; b_r <= ch_r[1]; c_r <= ch_r[2]; d_r <= ch_r[3];
          end else if (q_entry.last) begin
            st_r <= StPad;
          end
        end
        StPad: begin
          pad_first_r <= 1'b0;
          if (fill_r == 6'd63) begin
            st_r <= StComp;
            ret_r <= StPad;
            a_r <= ch_r[0]; b_r <= ch_r[1]; c_r <= ch_r[2]; d_r <= ch_r[3];
          end else if (fill_r == 6'd55) begin
            st_r <= StLen;
          end
        end
        StLen: if (fill_r == 6'd63) begin
          st_r <= StComp;
          ret_r <= StFin;
          a_r <= ch_r[0]; b_r <= ch_r[1]; c_r <= ch_r[2]; d_r <= ch_r[3];
        end
        StComp: begin
          a_r <= d_r; b_r <= t_v; c_r <= b_r; d_r <= c_r;
          rnd_r <= rnd_r + 1'b1;
          if (rnd_r == 6'd63) begin
            ch_r[0] <= ch_r[0] + d_r; ch_r[1] <= ch_r[1] + t_v;
            ch_r[2] <= ch_r[2] + b_r; ch_r[3] <= ch_r[3] + c_r;
            st_r <= ret_r;
          end
        end
        StFin: begin
          out_digest_low <= {ch_r[1], ch_r[0]};
          out_digest_high <= {ch_r[3], ch_r[2]};
          out_full_r <= 1'b1;
          ch_r[0] <= md5_pkg::InitA; ch_r[1] <= md5_pkg::InitB;
          ch_r[2] <= md5_pkg::InitC; ch_r[3] <= md5_pkg::InitD;
          len_r <= '0;
          fill_r <= '0;
          st_r <= StIdle;
        end
        default: st_r <= StIdle;
      endcase
    end
  end
endmodule

// ----- rtl/md5_message_digest_top.sv -----
// top level of the md5 digest block
// Usage: push one message byte per transfer on in_* (in_push / in_full).
// in_no_byte with in_final_item closes a message without a byte; in_no_byte
// alone is dropped. The digest of each message appears on out_digest_low /
// out_digest_high while out_empty is low and leaves on out_pop.
// Throughput: bytes enter at one per cycle into a short queue while in_full
// is low; the back end writes one byte per cycle while the queue holds bytes
// and no digest waits, then runs each 64-byte block through compression,
// one md5 step per cycle, and takes no byte meanwhile. Closing a message adds
// padding bytes at one per cycle, one or two compressions and a result load.
// Reset (synchronous, rst_n low) empties the queue, drops any partial
// message and loads the initial chaining values.
// If the digest is not popped, the back end stops before taking the next
// message's first byte and the queue fills, raising in_full.
module md5_message_digest_top #(
  parameter int unsigned QueueDepth = md5_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_no_byte,
  input  logic        in_final_item,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [63:0] out_digest_low,
  output logic [63:0] out_digest_high
);
  logic q_valid, q_take;
  md5_pkg::md5_entry_t q_entry;

  md5_front #(.Depth(QueueDepth)) u_front (
    .clk, .rst_n, .in_push, .in_full, .in_data_byte, .in_no_byte, .in_final_item,
    .q_valid, .q_take, .q_entry
  );

  md5_back u_back (
    .clk, .rst_n, .q_valid, .q_take, .q_entry,
    .out_empty, .out_pop, .out_digest_low, .out_digest_high
  );

  // queue never takes while full
  assert property (@(posedge clk) disable iff (!rst_n) in_full |-> !u_front.wr)
    else $error("write into full queue");
  // back end takes only from a non-empty queue
  assert property (@(posedge clk) disable iff (!rst_n) q_take |-> q_valid)
    else $error("take from empty queue");
  // a waiting digest holds until popped
  assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_digest_low)))
    else $error("digest changed while waiting");
endmodule
